>>> sv/atsm_pkg.sv
package atsm_pkg;

    localparam int SCREEN_ROWS = 8;
    localparam int SCREEN_COLS = 30;
    localparam int PARAM_LEN   = 15;
    localparam int CELLS       = SCREEN_ROWS * SCREEN_COLS;

    localparam int ROW_W  = 3;
    localparam int COL_W  = 5;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int PCNT_W = $clog2(PARAM_LEN + 1);
    localparam int PIDX_W = $clog2(PARAM_LEN);
    localparam int PCH_W  = 4;
    localparam int NUM_W  = 8;
    localparam int NUM_MAX = 255;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_H   = 8'h48;
    localparam logic [7:0] CH_UP_J   = 8'h4A;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_M   = 8'h6D;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    localparam logic [PCH_W-1:0] PCH_SEMI = 4'd10;
    localparam logic [PCH_W-1:0] PCH_TWO  = 4'd2;

    localparam logic [NUM_W-1:0] SGR_RESET   = 8'd0;
    localparam logic [NUM_W-1:0] SGR_REV_ON  = 8'd7;
    localparam logic [NUM_W-1:0] SGR_REV_OFF = 8'd27;
    localparam logic [NUM_W-1:0] SGR_FG_LO   = 8'd30;
    localparam logic [NUM_W-1:0] SGR_FG_HI   = 8'd37;
    localparam logic [NUM_W-1:0] SGR_BFG_LO  = 8'd90;
    localparam logic [NUM_W-1:0] SGR_BFG_HI  = 8'd97;

    typedef struct packed {
        logic [7:0] ch;
        logic [2:0] color;
        logic       rev;
    } cell_t;

    localparam cell_t CELL_BLANK = '{ch: CH_SPACE, color: 3'd0, rev: 1'b0};

endpackage

>>> sv/ansi_text_screen_mirror_top.sv
// Accept to m_tvalid: a byte feed passes ST_FEED, a cell read ST_READ and ST_RDATA,
// a CSI H, f or m final ST_FEED and then ST_WALK over its kept parameter characters.
// Throughput: one word in flight; s_tready is high only while idle, so a new word
// is taken the cycle after the result is taken. The parameter walk is the long path.
// Reset (aresetn low, synchronous): blank screen, all cells dirty, cursor home,
// text mode, default pen; takes effect at once, no clearing sweep.
module ansi_text_screen_mirror_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // in_byte[7:0], cell_row[10:8], cell_col[15:11]
    input  logic [atsm_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_char[7:0], out_color[10:8], out_reverse[11], out_cell_dirty[12],
    // out_row_dirty[13], cursor_row[16:14], cursor_col[21:17], zero[23:22]
    output logic [atsm_pkg::M_TDATA_W-1:0] m_tdata
);
    import atsm_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FEED  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_RDATA = 6'b001000,
        ST_WALK  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    typedef enum logic [3:0] {
        MD_TEXT = 4'b0001,
        MD_ESC  = 4'b0010,
        MD_CSI  = 4'b0100,
        MD_SKIP = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [2:0] color;
        logic       rev;
    } pen_t;

    function automatic pen_t sgr_apply(input logic [NUM_W-1:0] v, input pen_t pen);
        pen_t p;
        logic [NUM_W-1:0] d;
        p = pen;
        d = '0;
        if (v == SGR_RESET) begin
            p = '0;
        end else if (v == SGR_REV_ON) begin
            p.rev = 1'b1;
        end else if (v == SGR_REV_OFF) begin
            p.rev = 1'b0;
        end else if (v inside {[SGR_FG_LO:SGR_FG_HI]}) begin
            d = v - SGR_FG_LO;
            p.color = d[2:0];
            p.rev = 1'b0;
        end else if (v inside {[SGR_BFG_LO:SGR_BFG_HI]}) begin
            d = v - SGR_BFG_LO;
            p.color = d[2:0];
            p.rev = 1'b0;
        end
        return p;
    endfunction

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;

    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    pen_t              pen_reg, pen_next;
    logic [PCNT_W-1:0] param_cnt_reg, param_cnt_next;
    logic [PCH_W-1:0]  param_chars_reg [PARAM_LEN];

    logic [7:0]        byte_reg, byte_next;
    logic [ROW_W-1:0]  rd_row_reg, rd_row_next;
    logic [COL_W-1:0]  rd_col_reg, rd_col_next;
    logic              in_range_reg, in_range_next;

    logic [PCNT_W-1:0] pos_reg, pos_next;
    logic [NUM_W-1:0]  acc_reg, acc_next;
    logic              have_reg, have_next;
    logic [1:0]        nslot_reg, nslot_next;
    logic [NUM_W-1:0]  row_val_reg, row_val_next;
    logic [NUM_W-1:0]  col_val_reg, col_val_next;
    logic              fin_sgr_reg, fin_sgr_next;

    cell_t             out_cell_reg, out_cell_next;
    logic              out_cdirty_reg, out_cdirty_next;
    logic              out_rdirty_reg, out_rdirty_next;

    logic [SCREEN_COLS-1:0] dirty_reg [SCREEN_ROWS];

    logic              param_wr;
    logic [PCH_W-1:0]  param_wr_data;
    logic              scr_clear;
    logic              cell_wr;
    logic [ADDR_W-1:0] cell_wr_addr;
    cell_t             cell_wr_data;
    logic              cell_rd;
    logic [ADDR_W-1:0] cell_rd_addr;
    cell_t             cell_rd_data;
    logic              dirty_clr;

    logic [ROW_W:0]    row_inc;
    logic [ROW_W-1:0]  row_down;
    logic [ROW_W-1:0]  put_row;
    logic [COL_W-1:0]  put_col;
    logic [PCH_W-1:0]  pch;
    logic [NUM_W-1:0]  num_out;
    logic              walk_end;
    logic [NUM_W-1:0]  end_row;
    logic [NUM_W-1:0]  end_col;
    logic              rd_ok;

    atsm_num_unit u_num (
        .acc    (acc_reg),
        .digit  (pch),
        .result (num_out)
    );

    atsm_cell_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (scr_clear),
        .wr_en   (cell_wr),
        .wr_addr (cell_wr_addr),
        .wr_data (cell_wr_data),
        .rd_en   (cell_rd),
        .rd_addr (cell_rd_addr),
        .rd_data (cell_rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = M_TDATA_W'({cur_col_reg, cur_row_reg, out_rdirty_reg, out_cdirty_reg,
                                  out_cell_reg.rev, out_cell_reg.color, out_cell_reg.ch});

    // cursor helpers
    assign row_inc  = {1'b0, cur_row_reg} + (ROW_W + 1)'(1);
    assign row_down = (row_inc >= (ROW_W + 1)'(SCREEN_ROWS)) ? ROW_W'(SCREEN_ROWS - 1)
                                                            : row_inc[ROW_W-1:0];
    assign put_row  = (cur_col_reg >= COL_W'(SCREEN_COLS)) ? row_down : cur_row_reg;
    assign put_col  = (cur_col_reg >= COL_W'(SCREEN_COLS)) ? '0 : cur_col_reg;

    assign pch      = param_chars_reg[pos_reg[PIDX_W-1:0]];
    assign walk_end = (pos_reg == param_cnt_reg);
    assign end_row  = (nslot_reg == 2'd0) ? acc_reg : row_val_reg;
    assign end_col  = (nslot_reg == 2'd1) ? acc_reg : col_val_reg;

    assign rd_ok = ({1'b0, rd_row_reg} < (ROW_W + 1)'(SCREEN_ROWS))
                && (rd_col_reg < COL_W'(SCREEN_COLS));

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        pen_next        = pen_reg;
        param_cnt_next  = param_cnt_reg;
        byte_next       = byte_reg;
        rd_row_next     = rd_row_reg;
        rd_col_next     = rd_col_reg;
        in_range_next   = in_range_reg;
        pos_next        = pos_reg;
        acc_next        = acc_reg;
        have_next       = have_reg;
        nslot_next      = nslot_reg;
        row_val_next    = row_val_reg;
        col_val_next    = col_val_reg;
        fin_sgr_next    = fin_sgr_reg;
        out_cell_next   = out_cell_reg;
        out_cdirty_next = out_cdirty_reg;
        out_rdirty_next = out_rdirty_reg;
        param_wr        = 1'b0;
        param_wr_data   = (byte_reg == CH_SEMI) ? PCH_SEMI : PCH_W'(byte_reg - CH_ZERO);
        scr_clear       = 1'b0;
        cell_wr         = 1'b0;
        cell_wr_addr    = ADDR_W'(int'(put_row) * SCREEN_COLS + int'(put_col));
        cell_wr_data    = '{ch: byte_reg, color: pen_reg.color, rev: pen_reg.rev};
        cell_rd         = 1'b0;
        cell_rd_addr    = ADDR_W'(int'(rd_row_reg) * SCREEN_COLS + int'(rd_col_reg));
        dirty_clr       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    byte_next   = s_tdata[7:0];
                    rd_row_next = s_tdata[10:8];
                    rd_col_next = s_tdata[15:11];
                    if (s_tuser) begin
                        state_next = ST_READ;
                    end else begin
                        out_cell_next   = '0;
                        out_cdirty_next = 1'b0;
                        out_rdirty_next = 1'b0;
                        state_next      = ST_FEED;
                    end
                end
            end
            ST_FEED: begin
                state_next = ST_OUT;
                case (mode_reg)
                    MD_TEXT: begin
                        if (byte_reg == CH_ESC) begin
                            mode_next = MD_ESC;
                        end else if (byte_reg == CH_LF) begin
                            cur_row_next = row_down;
                            cur_col_next = '0;
                        end else if (byte_reg >= CH_SPACE) begin
                            cell_wr      = 1'b1;
                            cur_row_next = put_row;
                            cur_col_next = put_col + COL_W'(1);
                        end
                    end
                    MD_ESC: begin
                        if (byte_reg == CH_LBRACK) begin
                            mode_next      = MD_CSI;
                            param_cnt_next = '0;
                        end else begin
                            mode_next = MD_TEXT;
                        end
                    end
                    MD_CSI: begin
                        if (byte_reg == CH_UP_H || byte_reg == CH_LO_F
                            || byte_reg == CH_LO_M) begin
                            mode_next    = MD_TEXT;
                            pos_next     = '0;
                            acc_next     = '0;
                            have_next    = 1'b0;
                            nslot_next   = '0;
                            row_val_next = '0;
                            col_val_next = '0;
                            fin_sgr_next = (byte_reg == CH_LO_M);
                            state_next   = ST_WALK;
                        end else if (byte_reg == CH_UP_J) begin
                            mode_next = MD_TEXT;
                            if (param_cnt_reg == '0 || param_chars_reg[0] == PCH_TWO) begin
                                scr_clear    = 1'b1;
                                cur_row_next = '0;
                                cur_col_next = '0;
                            end
                        end else if (byte_reg == CH_QUEST) begin
                            mode_next = MD_SKIP;
                        end else if (byte_reg inside {[CH_ZERO:CH_NINE]}
                                     || byte_reg == CH_SEMI) begin
                            if (param_cnt_reg < PCNT_W'(PARAM_LEN)) begin
                                param_wr       = 1'b1;
                                param_cnt_next = param_cnt_reg + PCNT_W'(1);
                            end
                        end else begin
                            mode_next = MD_TEXT;
                        end
                    end
                    MD_SKIP: begin
                        if (byte_reg inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]}) begin
                            mode_next = MD_TEXT;
                        end
                    end
                    default: begin
                        mode_next = MD_TEXT;
                    end
                endcase
            end
            ST_WALK: begin
                if (!walk_end) begin
                    pos_next = pos_reg + PCNT_W'(1);
                    if (pch == PCH_SEMI) begin
                        if (have_reg) begin
                            acc_next  = '0;
                            have_next = 1'b0;
                            if (fin_sgr_reg) begin
                                pen_next = sgr_apply(acc_reg, pen_reg);
                            end else begin
                                if (nslot_reg == 2'd0) begin
                                    row_val_next = acc_reg;
                                end else if (nslot_reg == 2'd1) begin
                                    col_val_next = acc_reg;
                                end
                                if (nslot_reg != 2'd2) begin
                                    nslot_next = nslot_reg + 2'd1;
                                end
                            end
                        end
                    end else begin
                        acc_next  = num_out;
                        have_next = 1'b1;
                    end
                end else begin
                    state_next = ST_OUT;
                    if (fin_sgr_reg) begin
                        pen_next = sgr_apply(acc_reg, pen_reg);
                    end else begin
                        if (end_row == '0) begin
                            cur_row_next = '0;
                        end else if (end_row > NUM_W'(SCREEN_ROWS)) begin
                            cur_row_next = ROW_W'(SCREEN_ROWS - 1);
                        end else begin
                            cur_row_next = ROW_W'(end_row - NUM_W'(1));
                        end
                        if (end_col == '0) begin
                            cur_col_next = '0;
                        end else if (end_col > NUM_W'(SCREEN_COLS)) begin
                            cur_col_next = COL_W'(SCREEN_COLS - 1);
                        end else begin
                            cur_col_next = COL_W'(end_col - NUM_W'(1));
                        end
                    end
                end
            end
            ST_READ: begin
                in_range_next = rd_ok;
                cell_rd       = rd_ok;
                dirty_clr     = rd_ok;
                if (rd_ok) begin
                    out_cdirty_next = dirty_reg[rd_row_reg][rd_col_reg];
                    out_rdirty_next = |dirty_reg[rd_row_reg];
                end else begin
                    out_cdirty_next = 1'b0;
                    out_rdirty_next = 1'b0;
                end
                state_next = ST_RDATA;
            end
            ST_RDATA: begin
                out_cell_next = in_range_reg ? cell_rd_data : '0;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MD_TEXT;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            pen_reg       <= '0;
            param_cnt_reg <= '0;
            pos_reg       <= '0;
            have_reg      <= 1'b0;
            nslot_reg     <= '0;
            fin_sgr_reg   <= 1'b0;
            in_range_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            pen_reg       <= pen_next;
            param_cnt_reg <= param_cnt_next;
            pos_reg       <= pos_next;
            have_reg      <= have_next;
            nslot_reg     <= nslot_next;
            fin_sgr_reg   <= fin_sgr_next;
            in_range_reg  <= in_range_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg       <= byte_next;
        rd_row_reg     <= rd_row_next;
        rd_col_reg     <= rd_col_next;
        acc_reg        <= acc_next;
        row_val_reg    <= row_val_next;
        col_val_reg    <= col_val_next;
        out_cell_reg   <= out_cell_next;
        out_cdirty_reg <= out_cdirty_next;
        out_rdirty_reg <= out_rdirty_next;
        if (param_wr) begin
            param_chars_reg[param_cnt_reg[PIDX_W-1:0]] <= param_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || scr_clear) begin
            for (int r = 0; r < SCREEN_ROWS; r++) begin
                dirty_reg[r] <= '1;
            end
        end else if (cell_wr) begin
            dirty_reg[put_row][put_col] <= 1'b1;
        end else if (dirty_clr) begin
            dirty_reg[rd_row_reg][rd_col_reg] <= 1'b0;
        end
    end

endmodule

>>> sv/atsm_num_unit.sv
module atsm_num_unit (
    input  logic [atsm_pkg::NUM_W-1:0] acc,
    input  logic [atsm_pkg::PCH_W-1:0] digit,
    output logic [atsm_pkg::NUM_W-1:0] result
);
    import atsm_pkg::*;

    logic [NUM_W+3:0] wide;

    // acc * 10 + digit, saturating
    assign wide = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1)
                + {{NUM_W{1'b0}}, digit};
    assign result = (wide > (NUM_W + 4)'(NUM_MAX)) ? NUM_W'(NUM_MAX) : wide[NUM_W-1:0];

endmodule

>>> sv/atsm_cell_mem.sv
module atsm_cell_mem (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clear,
    input  logic                        wr_en,
    input  logic [atsm_pkg::ADDR_W-1:0] wr_addr,
    input  atsm_pkg::cell_t             wr_data,
    input  logic                        rd_en,
    input  logic [atsm_pkg::ADDR_W-1:0] rd_addr,
    output atsm_pkg::cell_t             rd_data
);
    import atsm_pkg::*;

    cell_t            mem [CELLS];
    logic [CELLS-1:0] valid_reg;
    cell_t            rd_word_reg;
    logic             rd_valid_reg;

    // unwritten cells read as blank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clear) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : CELL_BLANK;

endmodule

>>> sim/screen_mirror_checker.sv
`timescale 1ns / 100ps

module screen_mirror_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // in_byte[7:0], cell_row[10:8], cell_col[15:11]
    input  logic [atsm_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[0]
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // out_char[7:0], out_color[10:8], out_reverse[11], out_cell_dirty[12],
    // out_row_dirty[13], cursor_row[16:14], cursor_col[21:17], zero[23:22]
    input  logic [atsm_pkg::M_TDATA_W-1:0] m_tdata,
    output int                             fail_count,
    output int                             words_owed
);
    import atsm_pkg::*;

    typedef enum logic [3:0] {
        P_TEXT = 4'b0001,
        P_ESC  = 4'b0010,
        P_CSI  = 4'b0100,
        P_SKIP = 4'b1000
    } parse_mode_t;

    // msb first, so the struct lines up with m_tdata[21:0]
    typedef struct packed {
        logic [4:0] ccol;
        logic [2:0] crow;
        logic       line_dirty;
        logic       cell_dirty;
        logic       rev;
        logic [2:0] color;
        logic [7:0] ch;
    } screen_word_t;

    logic [7:0]       scr_ch    [CELLS];
    logic [2:0]       scr_color [CELLS];
    logic             scr_rev   [CELLS];
    logic             scr_dirty [CELLS];
    int               cur_r;
    int               cur_c;
    parse_mode_t      pmode;
    logic [PCH_W-1:0] pchars    [PARAM_LEN];
    int               pcount;
    logic [2:0]       pen_color;
    logic             pen_rev;

    screen_word_t     expected_words [$];
    int               mismatch_total = 0;

    task automatic wipe_screen();
        for (int i = 0; i < CELLS; i++) begin
            scr_ch[i]    = CH_SPACE;
            scr_color[i] = 3'd0;
            scr_rev[i]   = 1'b0;
            scr_dirty[i] = 1'b1;
        end
        cur_r = 0;
        cur_c = 0;
    endtask

    task automatic reset_mirror();
        wipe_screen();
        pmode     = P_TEXT;
        pcount    = 0;
        pen_color = 3'd0;
        pen_rev   = 1'b0;
        for (int i = 0; i < PARAM_LEN; i++)
            pchars[i] = '0;
    endtask

    // leading ';' skipped, digits saturate at NUM_MAX
    task automatic next_number(inout int pos, output int v);
        v = 0;
        while (pos < pcount && pchars[pos] == PCH_SEMI)
            pos++;
        while (pos < pcount && pchars[pos] < PCH_SEMI) begin
            v = v * 10 + int'(pchars[pos]);
            if (v > NUM_MAX)
                v = NUM_MAX;
            pos++;
        end
    endtask

    task automatic print_char(input logic [7:0] b);
        int ix;
        if (cur_c >= SCREEN_COLS) begin
            cur_c = 0;
            cur_r++;
        end
        if (cur_r >= SCREEN_ROWS)
            cur_r = SCREEN_ROWS - 1;
        ix = cur_r * SCREEN_COLS + cur_c;
        scr_ch[ix]    = b;
        scr_color[ix] = pen_color;
        scr_rev[ix]   = pen_rev;
        scr_dirty[ix] = 1'b1;
        cur_c++;
    endtask

    task automatic csi_final(input logic [7:0] fin);
        int pos;
        int r;
        int c;
        int v;
        int start;
        pos = 0;
        if (fin == CH_UP_H || fin == CH_LO_F) begin
            next_number(pos, r);
            next_number(pos, c);
            if (r < 1) r = 1;
            if (r > SCREEN_ROWS) r = SCREEN_ROWS;
            if (c < 1) c = 1;
            if (c > SCREEN_COLS) c = SCREEN_COLS;
            cur_r = r - 1;
            cur_c = c - 1;
        end else if (fin == CH_UP_J) begin
            if (pcount == 0 || pchars[0] == PCH_TWO)
                wipe_screen();
        end else if (fin == CH_LO_M) begin
            if (pcount == 0) begin
                pen_color = 3'd0;
                pen_rev   = 1'b0;
            end
            while (pos < pcount) begin
                start = pos;
                next_number(pos, v);
                if (pos == start)
                    pos++;
                if (v == int'(SGR_RESET)) begin
                    pen_color = 3'd0;
                    pen_rev   = 1'b0;
                end else if (v == int'(SGR_REV_ON)) begin
                    pen_rev = 1'b1;
                end else if (v == int'(SGR_REV_OFF)) begin
                    pen_rev = 1'b0;
                end else if (v >= int'(SGR_FG_LO) && v <= int'(SGR_FG_HI)) begin
                    pen_color = 3'(v - int'(SGR_FG_LO));
                    pen_rev   = 1'b0;
                end else if (v >= int'(SGR_BFG_LO) && v <= int'(SGR_BFG_HI)) begin
                    pen_color = 3'(v - int'(SGR_BFG_LO));
                    pen_rev   = 1'b0;
                end
            end
        end
        pmode = P_TEXT;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        case (pmode)
            P_TEXT: begin
                if (b == CH_ESC) begin
                    pmode = P_ESC;
                end else if (b == CH_LF) begin
                    cur_r++;
                    if (cur_r >= SCREEN_ROWS)
                        cur_r = SCREEN_ROWS - 1;
                    cur_c = 0;
                end else if (b >= CH_SPACE) begin
                    print_char(b);
                end
            end
            P_ESC: begin
                if (b == CH_LBRACK) begin
                    pmode  = P_CSI;
                    pcount = 0;
                end else begin
                    pmode = P_TEXT;
                end
            end
            P_CSI: begin
                if (b == CH_UP_H || b == CH_LO_F || b == CH_UP_J || b == CH_LO_M) begin
                    csi_final(b);
                end else if (b == CH_QUEST) begin
                    pmode = P_SKIP;
                end else if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI) begin
                    if (pcount < PARAM_LEN) begin
                        pchars[pcount] = (b == CH_SEMI) ? PCH_SEMI : PCH_W'(b - CH_ZERO);
                        pcount++;
                    end
                end else begin
                    pmode = P_TEXT;
                end
            end
            default: begin
                if ((b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z))
                    pmode = P_TEXT;
            end
        endcase
    endtask

    task automatic mirror_step(input logic is_read, input logic [S_TDATA_W-1:0] d,
                               output screen_word_t w);
        int r;
        int c;
        int base;
        w = '0;
        if (!is_read) begin
            parse_byte(d[7:0]);
        end else begin
            r = int'(d[10:8]);
            c = int'(d[15:11]);
            if (r < SCREEN_ROWS && c < SCREEN_COLS) begin
                base = r * SCREEN_COLS;
                for (int i = 0; i < SCREEN_COLS; i++)
                    w.line_dirty = w.line_dirty | scr_dirty[base + i];
                w.ch         = scr_ch[base + c];
                w.color      = scr_color[base + c];
                w.rev        = scr_rev[base + c];
                w.cell_dirty = scr_dirty[base + c];
                scr_dirty[base + c] = 1'b0;
            end
        end
        w.crow = 3'(cur_r);
        w.ccol = 5'(cur_c);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
            mismatch_total++;
        end
    endtask

    always @(posedge aclk) begin
        screen_word_t want;
        screen_word_t got;
        if (!aresetn) begin
            reset_mirror();
            expected_words.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[21:0];
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word 0x%0h", $time, m_tdata);
                    mismatch_total++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("out_char", want.ch, got.ch);
                    check_field("out_color", want.color, got.color);
                    check_field("out_reverse", want.rev, got.rev);
                    check_field("out_cell_dirty", want.cell_dirty, got.cell_dirty);
                    check_field("out_row_dirty", want.line_dirty, got.line_dirty);
                    check_field("cursor_row", want.crow, got.crow);
                    check_field("cursor_col", want.ccol, got.ccol);
                end
            end
            if (s_tvalid && s_tready) begin
                mirror_step(s_tuser, s_tdata, want);
                expected_words.push_back(want);
            end
        end
        fail_count <= mismatch_total;
        words_owed <= expected_words.size();
    end

endmodule

>>> sim/ansi_text_screen_mirror_top_tb.sv
`timescale 1ns / 100ps

module ansi_text_screen_mirror_top_tb;
    import atsm_pkg::*;

    localparam int RANDOM_WORDS = 1290;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500000;

    typedef enum logic {REQ_FEED, REQ_READ} req_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int chk_fails;
    int chk_owed;
    int words_sent   = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_reqs    = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int cycle_count  = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    ansi_text_screen_mirror_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    screen_mirror_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (chk_fails),
        .words_owed (chk_owed)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_reqs != hold_seen) begin
            m_tready  <= 1'b0;
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ansi_text_screen_mirror_top: mismatch");
            $finish;
        end
    end

    task automatic send_word(input req_t rq, input logic [S_TDATA_W-1:0] d);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= rq;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        words_sent++;
    endtask

    task automatic feed(input logic [7:0] b);
        send_word(REQ_FEED, {5'($urandom), 3'($urandom), b});
    endtask

    task automatic read_cell(input int r, input int c);
        send_word(REQ_READ, {5'(c), 3'(r), 8'($urandom)});
    endtask

    task automatic send_number(input int v);
        if (v >= 100)
            feed(CH_ZERO + 8'(v / 100));
        if (v >= 10)
            feed(CH_ZERO + 8'((v / 10) % 10));
        feed(CH_ZERO + 8'(v % 10));
    endtask

    task automatic csi_open();
        feed(CH_ESC);
        feed(CH_LBRACK);
    endtask

    // lower valid, then wait out every owed word
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chk_owed != 0)
            @(posedge aclk);
    endtask

    function automatic int pick_number();
        case ($urandom_range(0, 9))
            6, 7:    return $urandom_range(0, 99);
            8:       return $urandom_range(200, 999);
            9:       return $urandom_range(90, 97);
            default: return $urandom_range(0, 35);
        endcase
    endfunction

    function automatic int pick_sgr();
        case ($urandom_range(0, 5))
            0:       return int'(SGR_RESET);
            1:       return int'(SGR_REV_ON);
            2:       return int'(SGR_REV_OFF);
            3:       return $urandom_range(SGR_FG_LO, SGR_FG_HI);
            4:       return $urandom_range(SGR_BFG_LO, SGR_BFG_HI);
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    function automatic logic [7:0] pick_final();
        case ($urandom_range(0, 3))
            0:       return CH_UP_H;
            1:       return CH_LO_F;
            2:       return CH_UP_J;
            default: return CH_LO_M;
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        return $urandom_range(0, 1) ? CH_UP_A + 8'($urandom_range(0, 25))
                                    : CH_LO_A + 8'($urandom_range(0, 25));
    endfunction

    function automatic int pick_col();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(SCREEN_COLS, 31)
                                            : $urandom_range(0, SCREEN_COLS - 1);
    endfunction

    task automatic random_burst();
        int kind;
        int n;
        int r;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            repeat ($urandom_range(1, 12))
                feed(8'($urandom_range(32, 255)));
        end else if (kind < 44) begin
            repeat ($urandom_range(1, 6))
                read_cell($urandom_range(0, SCREEN_ROWS - 1), pick_col());
        end else if (kind < 47) begin
            r = $urandom_range(0, SCREEN_ROWS - 1);
            for (int c = 0; c < SCREEN_COLS; c++)
                read_cell(r, c);
            read_cell(r, $urandom_range(0, SCREEN_COLS - 1));
        end else if (kind < 55) begin
            csi_open();
            if ($urandom_range(0, 5) == 0)
                feed(CH_SEMI);
            if ($urandom_range(0, 4) != 0)
                send_number(pick_number());
            if ($urandom_range(0, 4) != 0) begin
                feed(CH_SEMI);
                if ($urandom_range(0, 4) != 0)
                    send_number(pick_number());
            end
            feed($urandom_range(0, 1) ? CH_UP_H : CH_LO_F);
        end else if (kind < 65) begin
            csi_open();
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
                if (i > 0)
                    feed(CH_SEMI);
                send_number(pick_sgr());
            end
            if ($urandom_range(0, 7) == 0)
                feed(CH_SEMI);
            feed(CH_LO_M);
        end else if (kind < 68) begin
            csi_open();
            case ($urandom_range(0, 3))
                0:       ;
                1:       send_number(2);
                2:       send_number($urandom_range(0, 1));
                default: send_number($urandom_range(20, 29));
            endcase
            feed(CH_UP_J);
        end else if (kind < 74) begin
            case ($urandom_range(0, 2))
                0:       feed(CH_LF);
                1:       feed(8'h0D);
                default: feed(8'($urandom_range(0, 31)));
            endcase
        end else if (kind < 78) begin
            csi_open();
            feed(CH_QUEST);
            repeat ($urandom_range(0, 4))
                feed(8'($urandom_range(32, 64)));
            feed(pick_letter());
        end else if (kind < 81) begin
            csi_open();
            repeat ($urandom_range(14, 22))
                feed($urandom_range(0, 3) == 0 ? CH_SEMI : CH_ZERO + 8'($urandom_range(0, 9)));
            feed(pick_final());
        end else if (kind < 87) begin
            feed(CH_ESC);
            if ($urandom_range(0, 1)) begin
                feed(8'($urandom));
            end else begin
                feed(CH_LBRACK);
                repeat ($urandom_range(0, 3))
                    feed(CH_ZERO + 8'($urandom_range(0, 9)));
                feed(8'($urandom));
            end
        end else begin
            repeat ($urandom_range(1, 4))
                send_word($urandom_range(0, 1) ? REQ_READ : REQ_FEED, 16'($urandom));
        end
    endtask

    initial begin
        int phase_end;
        bit hold_done;
        hold_done = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corners, out-of-range read, print/wrap/clamp, SGR, clear, dropped escapes
        read_cell(0, 0);
        read_cell(SCREEN_ROWS - 1, SCREEN_COLS - 1);
        read_cell(2, 31);
        feed(CH_UP_A);
        feed(8'hFF);
        feed(CH_LF);
        feed(8'h0D);
        csi_open();
        send_number(SCREEN_ROWS);
        feed(CH_SEMI);
        send_number(SCREEN_COLS);
        feed(CH_UP_H);
        feed(CH_LO_Z);
        feed(CH_UP_Z);
        csi_open();
        send_number(int'(SGR_REV_ON));
        feed(CH_LO_M);
        csi_open();
        feed(CH_UP_J);
        feed(CH_ESC);
        feed(CH_LO_Z);
        csi_open();
        feed(CH_QUEST);
        feed(CH_LO_F);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 77 : 0;
            snk_idle_pct <= (ph == 0) ? 77 : (ph == 1) ? 16 : 0;
            phase_end = words_sent + RANDOM_WORDS / 3;
            while (words_sent < phase_end) begin
                random_burst();
                if (!hold_done && words_sent > phase_end - 200) begin
                    hold_reqs <= hold_reqs + 1;
                    hold_done = 1'b1;
                end
            end
            drain();
        end

        repeat (30) @(posedge aclk);
        if (chk_fails == 0 && chk_owed == 0) begin
            $display("ansi_text_screen_mirror_top: match");
        end else begin
            $display("ansi_text_screen_mirror_top: mismatch");
        end
        $finish;
    end

endmodule
